@@ hdl/pio_pkg.sv @@
// ----------------------------------------------------------------------------
// pio_pkg
// Shared types, widths and codes of the point in obstacles test.
// ----------------------------------------------------------------------------
package pio_pkg;

    localparam int COORD_W   = 24;
    localparam int OWNER_W   = 6;
    localparam int MAX_EDGES = 1024;
    localparam int ADDR_W    = $clog2(MAX_EDGES);
    localparam int CNT_W     = ADDR_W + 1;

    localparam int DIFF_W  = COORD_W + 1;
    localparam int PROD_W  = 2 * DIFF_W;
    localparam int NUM_W   = 2 * DIFF_W + 2;
    localparam int SPLIT_W = NUM_W / 2;
    localparam int WIDE_W  = NUM_W + DIFF_W + 1;

    localparam int MODE_W     = 2;
    localparam int IN_DATA_W  = ((OWNER_W + 6 * COORD_W + 7) / 8) * 8;
    localparam int OUT_DATA_W = ((2 + OWNER_W + 7) / 8) * 8;

    localparam int OFS_OWNER = 0;
    localparam int OFS_SX    = OFS_OWNER + OWNER_W;
    localparam int OFS_SY    = OFS_SX + COORD_W;
    localparam int OFS_EX    = OFS_SY + COORD_W;
    localparam int OFS_EY    = OFS_EX + COORD_W;
    localparam int OFS_PX    = OFS_EY + COORD_W;
    localparam int OFS_PY    = OFS_PX + COORD_W;

    typedef enum logic [MODE_W-1:0] {
        MODE_APPEND = 2'd0,
        MODE_CLEAR  = 2'd1,
        MODE_QUERY  = 2'd2
    } mode_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_FETCH,
        ST_LOAD,
        ST_MUL1,
        ST_EVAL,
        ST_MUL2,
        ST_SUM,
        ST_CMP,
        ST_FIN,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic signed [COORD_W-1:0] ey;
        logic signed [COORD_W-1:0] ex;
        logic signed [COORD_W-1:0] sy;
        logic signed [COORD_W-1:0] sx;
        logic [OWNER_W-1:0]        owner;
    } edge_t;

    localparam int EDGE_W = $bits(edge_t);

    typedef struct packed {
        logic append;
        logic clear;
        logic start;
        logic rd_en;
        logic load;
        logic mul1;
        logic eval;
        logic mul2;
        logic sum;
        logic cmp;
        logic fin;
        logic out_load;
    } cmd_t;

    typedef struct packed {
        logic at_end;
        logic run_hit;
        logic cand;
    } stat_t;

endpackage

@@ hdl/pio_ram.sv @@
// ----------------------------------------------------------------------------
// pio_ram
// Generic single write port, single read port RAM with registered read.
// ----------------------------------------------------------------------------
module pio_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

@@ hdl/pio_ctrl.sv @@
// ----------------------------------------------------------------------------
// pio_ctrl
// Sequencer: takes transfers, walks the edge store per query, holds m_tvalid.
// ----------------------------------------------------------------------------
module pio_ctrl (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [pio_pkg::MODE_W-1:0]    s_tuser,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output pio_pkg::cmd_t                 cmd,
    input  pio_pkg::stat_t                stat
);

    pio_pkg::state_t state_reg, state_next;
    logic            m_valid_reg, m_valid_next;
    logic            accept;
    logic            out_free;
    pio_pkg::mode_t  mode;

    assign mode     = pio_pkg::mode_t'(s_tuser);
    assign s_tready = (state_reg == pio_pkg::ST_IDLE);
    assign accept   = s_tvalid && s_tready;
    assign out_free = !m_valid_reg || m_tready;
    assign m_tvalid = m_valid_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= pio_pkg::ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            pio_pkg::ST_IDLE: begin
                if (accept && mode == pio_pkg::MODE_QUERY) begin
                    state_next = pio_pkg::ST_FETCH;
                end
            end
            pio_pkg::ST_FETCH: begin
                state_next = stat.at_end ? pio_pkg::ST_FIN : pio_pkg::ST_LOAD;
            end
            pio_pkg::ST_LOAD: begin
                state_next = stat.run_hit ? pio_pkg::ST_DONE : pio_pkg::ST_MUL1;
            end
            pio_pkg::ST_MUL1: state_next = pio_pkg::ST_EVAL;
            pio_pkg::ST_EVAL: begin
                state_next = stat.cand ? pio_pkg::ST_MUL2 : pio_pkg::ST_FETCH;
            end
            pio_pkg::ST_MUL2: state_next = pio_pkg::ST_SUM;
            pio_pkg::ST_SUM:  state_next = pio_pkg::ST_CMP;
            pio_pkg::ST_CMP:  state_next = pio_pkg::ST_FETCH;
            pio_pkg::ST_FIN:  state_next = pio_pkg::ST_DONE;
            pio_pkg::ST_DONE: begin
                if (out_free) begin
                    state_next = pio_pkg::ST_IDLE;
                end
            end
            default: state_next = pio_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        cmd          = '0;
        m_valid_next = m_valid_reg && !m_tready;
        unique case (state_reg)
            pio_pkg::ST_IDLE: begin
                if (accept) begin
                    case (mode)
                        pio_pkg::MODE_APPEND: cmd.append = 1'b1;
                        pio_pkg::MODE_CLEAR:  cmd.clear  = 1'b1;
                        pio_pkg::MODE_QUERY:  cmd.start  = 1'b1;
                        default: ;
                    endcase
                end
            end
            pio_pkg::ST_FETCH: cmd.rd_en = !stat.at_end;
            pio_pkg::ST_LOAD:  cmd.load  = 1'b1;
            pio_pkg::ST_MUL1:  cmd.mul1  = 1'b1;
            pio_pkg::ST_EVAL:  cmd.eval  = 1'b1;
            pio_pkg::ST_MUL2:  cmd.mul2  = 1'b1;
            pio_pkg::ST_SUM:   cmd.sum   = 1'b1;
            pio_pkg::ST_CMP:   cmd.cmp   = 1'b1;
            pio_pkg::ST_FIN:   cmd.fin   = 1'b1;
            pio_pkg::ST_DONE: begin
                if (out_free) begin
                    cmd.out_load = 1'b1;
                    m_valid_next = 1'b1;
                end
            end
            default: ;
        endcase
    end

endmodule

@@ hdl/pio_dp.sv @@
// ----------------------------------------------------------------------------
// pio_dp
// Datapath: edge store, exact crossing arithmetic, best edge and result.
// ----------------------------------------------------------------------------
module pio_dp (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic [pio_pkg::IN_DATA_W-1:0]     s_tdata,
    output logic [pio_pkg::OUT_DATA_W-1:0]    m_tdata,
    input  pio_pkg::cmd_t                     cmd,
    output pio_pkg::stat_t                    stat
);

    localparam int W  = pio_pkg::COORD_W;
    localparam int DW = pio_pkg::DIFF_W;
    localparam int PW = pio_pkg::PROD_W;
    localparam int NW = pio_pkg::NUM_W;
    localparam int SW = pio_pkg::SPLIT_W;
    localparam int XW = pio_pkg::WIDE_W;
    localparam int OW = pio_pkg::OWNER_W;

    // store control
    logic [pio_pkg::CNT_W-1:0] held_reg;
    logic [pio_pkg::CNT_W-1:0] idx_reg;
    logic                      ovf_reg;
    logic                      full;
    logic                      wr_en;
    pio_pkg::edge_t            wr_edge;
    pio_pkg::edge_t            rd_edge;

    assign full = (held_reg == pio_pkg::CNT_W'(pio_pkg::MAX_EDGES));
    assign wr_en = cmd.append && !full;

    assign wr_edge.owner = s_tdata[pio_pkg::OFS_OWNER +: OW];
    assign wr_edge.sx    = s_tdata[pio_pkg::OFS_SX +: W];
    assign wr_edge.sy    = s_tdata[pio_pkg::OFS_SY +: W];
    assign wr_edge.ex    = s_tdata[pio_pkg::OFS_EX +: W];
    assign wr_edge.ey    = s_tdata[pio_pkg::OFS_EY +: W];

    pio_ram #(
        .WIDTH (pio_pkg::EDGE_W),
        .DEPTH (pio_pkg::MAX_EDGES)
    ) u_ram (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (held_reg[pio_pkg::ADDR_W-1:0]),
        .wr_data (wr_edge),
        .rd_en   (cmd.rd_en),
        .rd_addr (idx_reg[pio_pkg::ADDR_W-1:0]),
        .rd_data (rd_edge)
    );

    // query registers
    logic signed [W-1:0]  px_reg, py_reg;
    logic signed [W-1:0]  x1_reg, y1_reg, x2_reg, y2_reg;
    logic signed [DW-1:0] dy1_reg, dx21_reg, dx1_reg, d_reg;
    logic                 up_reg;
    logic [OW-1:0]        owner_reg;
    logic signed [PW-1:0] q1_reg, q2_reg, x1d_reg;
    logic signed [NW-1:0] n_reg;
    logic signed [NW-1:0] pl_reg, ph_reg, rl_reg, rh_reg;
    logic signed [XW-1:0] lhs_reg, rhs_reg;
    logic                 found_reg;
    logic signed [NW-1:0] bn_reg;
    logic signed [DW-1:0] bd_reg;
    logic signed [W-1:0]  bx2_reg;
    logic                 bup_reg;
    logic                 res_in_reg;
    logic [OW-1:0]        res_hit_reg;
    logic [pio_pkg::OUT_DATA_W-1:0] out_reg;

    // load stage
    logic                 swap;
    logic signed [W-1:0]  lx1, ly1, lx2, ly2;
    logic                 boundary;
    logic                 run_hit;

    assign swap = rd_edge.sy > rd_edge.ey;
    assign lx1  = swap ? rd_edge.ex : rd_edge.sx;
    assign ly1  = swap ? rd_edge.ey : rd_edge.sy;
    assign lx2  = swap ? rd_edge.sx : rd_edge.ex;
    assign ly2  = swap ? rd_edge.sy : rd_edge.ey;
    assign boundary = (idx_reg != '0) && (rd_edge.owner != owner_reg);
    assign run_hit  = boundary && found_reg && !bup_reg;

    // eval stage
    logic                 span, on_edge, cand;
    logic signed [W-1:0]  lox, hix;

    assign span    = (y1_reg <= py_reg) && (py_reg <= y2_reg);
    assign lox     = (x1_reg < x2_reg) ? x1_reg : x2_reg;
    assign hix     = (x1_reg < x2_reg) ? x2_reg : x1_reg;
    assign on_edge = (q1_reg == q2_reg) && span && (lox <= px_reg) && (px_reg <= hix);
    assign cand    = !on_edge && span && (y1_reg != y2_reg) && (q1_reg > q2_reg);

    // compare stage
    logic take;
    assign take = !found_reg || (lhs_reg < rhs_reg) ||
                  ((lhs_reg == rhs_reg) && (x2_reg < bx2_reg));

    assign stat.at_end  = (idx_reg == held_reg);
    assign stat.run_hit = run_hit;
    assign stat.cand    = cand;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            held_reg  <= '0;
            ovf_reg   <= 1'b0;
            idx_reg   <= '0;
            found_reg <= 1'b0;
        end else begin
            if (cmd.append) begin
                if (full) begin
                    ovf_reg <= 1'b1;
                end else begin
                    held_reg <= held_reg + 1'b1;
                end
            end
            if (cmd.clear) begin
                held_reg <= '0;
                ovf_reg  <= 1'b0;
            end
            if (cmd.start) begin
                idx_reg   <= '0;
                found_reg <= 1'b0;
            end
            if (cmd.load && boundary) begin
                found_reg <= 1'b0;
            end
            if (cmd.eval && !cand) begin
                idx_reg <= idx_reg + 1'b1;
            end
            if (cmd.cmp) begin
                idx_reg <= idx_reg + 1'b1;
                if (take) begin
                    found_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.start) begin
            px_reg      <= s_tdata[pio_pkg::OFS_PX +: W];
            py_reg      <= s_tdata[pio_pkg::OFS_PY +: W];
            res_in_reg  <= 1'b0;
            res_hit_reg <= '0;
        end
        if (cmd.load) begin
            x1_reg    <= lx1;
            y1_reg    <= ly1;
            x2_reg    <= lx2;
            y2_reg    <= ly2;
            up_reg    <= rd_edge.ey > rd_edge.sy;
            dy1_reg   <= DW'(py_reg) - DW'(ly1);
            dx21_reg  <= DW'(lx2) - DW'(lx1);
            dx1_reg   <= DW'(px_reg) - DW'(lx1);
            d_reg     <= DW'(ly2) - DW'(ly1);
            owner_reg <= rd_edge.owner;
            if (run_hit) begin
                res_in_reg  <= 1'b1;
                res_hit_reg <= owner_reg;
            end
        end
        if (cmd.mul1) begin
            q1_reg  <= dy1_reg * dx21_reg;
            q2_reg  <= dx1_reg * d_reg;
            x1d_reg <= DW'(x1_reg) * d_reg;
        end
        if (cmd.eval) begin
            n_reg <= NW'(x1d_reg) + NW'(q1_reg);
        end
        if (cmd.mul2) begin
            pl_reg <= $signed({1'b0, n_reg[SW-1:0]}) * bd_reg;
            ph_reg <= $signed(n_reg[NW-1:SW]) * bd_reg;
            rl_reg <= $signed({1'b0, bn_reg[SW-1:0]}) * d_reg;
            rh_reg <= $signed(bn_reg[NW-1:SW]) * d_reg;
        end
        if (cmd.sum) begin
            lhs_reg <= (XW'(ph_reg) <<< SW) + XW'(pl_reg);
            rhs_reg <= (XW'(rh_reg) <<< SW) + XW'(rl_reg);
        end
        if (cmd.cmp && take) begin
            bn_reg  <= n_reg;
            bd_reg  <= d_reg;
            bx2_reg <= x2_reg;
            bup_reg <= up_reg;
        end
        if (cmd.fin && found_reg && !bup_reg) begin
            res_in_reg  <= 1'b1;
            res_hit_reg <= owner_reg;
        end
        if (cmd.out_load) begin
            out_reg <= pio_pkg::OUT_DATA_W'({ovf_reg, res_hit_reg, res_in_reg});
        end
    end

    assign m_tdata = out_reg;

endmodule

@@ hdl/point_in_obstacles_test.sv @@
// ----------------------------------------------------------------------------
// point_in_obstacles_test
// Edge store with exact nearest-edge ray test of a point against obstacles.
// ----------------------------------------------------------------------------
//  channel   dir  tdata                                   tuser
//  s_        in   owner, sx, sy, ex, ey, px, py (152 b)   mode (2 b)
//  m_        out  inside_res, hit_polygon, store_full     -
//
//  a query walks the stored edges through fetch, load, multiply and eval,
//  a candidate also through multiply, sum and compare, set by the single
//  edge memory read port and the two-step exact compare of crossing positions
//  no clearing pass: the fill count bounds every read, ready right after reset
//  a query's result waits in the output register; new transfers are taken
//  while it waits, and a later query holds in its last step until it drains
module point_in_obstacles_test (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    // polygon_index, start_x, start_y, end_x, end_y, point_x, point_y, zero pad
    input  logic [pio_pkg::IN_DATA_W-1:0]    s_tdata,
    // mode
    input  logic [pio_pkg::MODE_W-1:0]       s_tuser,
    output logic                             m_tvalid,
    input  logic                             m_tready,
    // inside_res, hit_polygon, store_full
    output logic [pio_pkg::OUT_DATA_W-1:0]   m_tdata
);

    pio_pkg::cmd_t  cmd;
    pio_pkg::stat_t stat;

    pio_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .cmd      (cmd),
        .stat     (stat)
    );

    pio_dp u_dp (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tdata (s_tdata),
        .m_tdata (m_tdata),
        .cmd     (cmd),
        .stat    (stat)
    );

endmodule

@@ hdl/pio_checker.sv @@
// ----------------------------------------------------------------------------
// pio_checker
// Port level checks of the point in obstacles test, bound to the top level.
// ----------------------------------------------------------------------------
module pio_checker (
    input logic                             aclk,
    input logic                             aresetn,
    input logic                             s_tvalid,
    input logic                             s_tready,
    input logic [pio_pkg::MODE_W-1:0]       s_tuser,
    input logic                             m_tvalid,
    input logic                             m_tready,
    input logic [pio_pkg::OUT_DATA_W-1:0]   m_tdata
);

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed while stalled");

    a_miss_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tdata[0] |-> m_tdata[6:1] == '0)
        else $error("hit polygon set without inside");

    a_store_quiet: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready && s_tuser != pio_pkg::MODE_QUERY && !m_tvalid
        |=> !m_tvalid)
        else $error("result without a query");

    a_query_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready && s_tuser == pio_pkg::MODE_QUERY |=> !s_tready)
        else $error("transfer taken during a query");

endmodule

bind point_in_obstacles_test pio_checker u_chk (.*);

@@ tb/tb_point_in_obstacles_test.sv @@
// ----------------------------------------------------------------------------
// tb_point_in_obstacles_test
// Self-checking bench for the edge store and point in obstacles query. A
// queue of pending transfers feeds a driver; every accepted query is answered
// by an exact in-bench model of the nearest-edge ray test, and each result
// transfer is checked field by field against the oldest expected answer.
// ----------------------------------------------------------------------------
module tb_point_in_obstacles_test;

    localparam logic [pio_pkg::MODE_W-1:0] MODE_UNUSED = 2'd3;
    localparam int IDLE_LIMIT = 40000;
    localparam int LONG_HOLD  = 300;
    localparam int CW = pio_pkg::COORD_W;
    localparam int OW = pio_pkg::OWNER_W;

    typedef logic signed [127:0] wide_t;

    typedef struct {
        logic [pio_pkg::MODE_W-1:0] mode;
        logic [OW-1:0]              owner;
        logic [CW-1:0]              sx, sy, ex, ey, px, py;
        bit                         sync;
        bit                         hold;
    } xfer_t;

    typedef struct packed {
        logic          full;
        logic [OW-1:0] hit;
        logic          in_poly;
    } answer_t;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic s_tvalid = 1'b0;
    logic s_tready;
    logic [pio_pkg::IN_DATA_W-1:0] s_tdata = '0;
    logic [pio_pkg::MODE_W-1:0] s_tuser = MODE_UNUSED;
    logic m_tvalid;
    logic m_tready = 1'b0;
    logic [pio_pkg::OUT_DATA_W-1:0] m_tdata;

    point_in_obstacles_test DUT (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
    );

    xfer_t   pending[$];
    answer_t answers[$];
    bit      calm = 0;
    bit      taken = 0;
    bit      hold_req = 0;
    int      hold_cnt = 0;
    int      send_gap = 0;
    int      recv_gap = 0;
    int      mismatches = 0;
    int      idle_cycles = 0;

    // shadow edge store
    logic [OW-1:0] seg_owner[pio_pkg::MAX_EDGES];
    longint seg_sx[pio_pkg::MAX_EDGES], seg_sy[pio_pkg::MAX_EDGES];
    longint seg_ex[pio_pkg::MAX_EDGES], seg_ey[pio_pkg::MAX_EDGES];
    int  seg_count = 0;
    bit  seg_dropped = 0;

    initial begin
        forever #6 aclk = ~aclk;
    end

    function automatic longint sext24(logic [CW-1:0] v);
        logic signed [CW-1:0] s;
        s = v;
        return s;
    endfunction

    function automatic wide_t mulw(wide_t a, wide_t b);
        return a * b;
    endfunction

    function automatic answer_t locate_point(longint x, longint y);
        answer_t r;
        bit found, best_up, up, on_edge;
        wide_t best_n, n, cr, lhs, rhs;
        longint best_d, best_x2, x1, y1, x2, y2, t, d, lox, hix;
        int c;
        r = '0;
        r.full = seg_dropped;
        found = 0; best_up = 0; best_n = 0; best_d = 1; best_x2 = 0;
        for (int i = 0; i < seg_count; i++) begin
            x1 = seg_sx[i]; y1 = seg_sy[i]; x2 = seg_ex[i]; y2 = seg_ey[i];
            up = seg_ey[i] > seg_sy[i];
            if (y1 > y2) begin
                t = x1; x1 = x2; x2 = t;
                t = y1; y1 = y2; y2 = t;
            end
            cr = mulw(y1 - y2, x - x1) - mulw(y - y1, x1 - x2);
            lox = (x1 < x2) ? x1 : x2;
            hix = (x1 < x2) ? x2 : x1;
            on_edge = (cr == 0) && y1 <= y && y <= y2 && lox <= x && x <= hix;
            lhs = mulw(y - y1, x2 - x1);
            rhs = mulw(x - x1, y2 - y1);
            if (!on_edge && y1 <= y && y <= y2 && y1 != y2 && lhs > rhs) begin
                d = y2 - y1;
                n = mulw(x1, d) + mulw(y - y1, x2 - x1);
                if (!found) c = -1;
                else if (n * wide_t'(best_d) < best_n * wide_t'(d)) c = -1;
                else if (n * wide_t'(best_d) == best_n * wide_t'(d)) c = 0;
                else c = 1;
                if (c < 0 || (c == 0 && x2 < best_x2)) begin
                    found = 1; best_n = n; best_d = d; best_x2 = x2; best_up = up;
                end
            end
            if (i + 1 == seg_count || seg_owner[i + 1] != seg_owner[i]) begin
                if (found && !best_up) begin
                    r.in_poly = 1'b1;
                    r.hit = seg_owner[i];
                    return r;
                end
                found = 0;
            end
        end
        return r;
    endfunction

    // model update on every accepted input transfer
    always @(posedge aclk) begin
        logic [OW-1:0] own;
        own = s_tdata[pio_pkg::OFS_OWNER +: OW];
        taken <= s_tvalid && s_tready;
        if (aresetn && s_tvalid && s_tready) begin
            case (s_tuser)
                pio_pkg::MODE_APPEND: begin
                    if (seg_count >= pio_pkg::MAX_EDGES) begin
                        seg_dropped = 1;
                    end else begin
                        seg_owner[seg_count] = own;
                        seg_sx[seg_count] = sext24(s_tdata[pio_pkg::OFS_SX +: CW]);
                        seg_sy[seg_count] = sext24(s_tdata[pio_pkg::OFS_SY +: CW]);
                        seg_ex[seg_count] = sext24(s_tdata[pio_pkg::OFS_EX +: CW]);
                        seg_ey[seg_count] = sext24(s_tdata[pio_pkg::OFS_EY +: CW]);
                        seg_count++;
                    end
                end
                pio_pkg::MODE_CLEAR: begin
                    seg_count = 0;
                    seg_dropped = 0;
                end
                pio_pkg::MODE_QUERY: begin
                    answers.push_back(locate_point(sext24(s_tdata[pio_pkg::OFS_PX +: CW]),
                                                   sext24(s_tdata[pio_pkg::OFS_PY +: CW])));
                end
                default: ;
            endcase
        end
    end

    // result checker
    always @(posedge aclk) begin
        answer_t got, want;
        if (aresetn && m_tvalid && m_tready) begin
            got = m_tdata[7:0];
            if (answers.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result transfer: %h", m_tdata);
            end else begin
                want = answers.pop_front();
                if (got.in_poly !== want.in_poly || got.hit !== want.hit ||
                    got.full !== want.full) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("result mismatch: inside %b/%b hit %0d/%0d full %b/%b",
                                 want.in_poly, got.in_poly, want.hit, got.hit,
                                 want.full, got.full);
                end
            end
        end
    end

    // watchdog on cycles with no transfer on either side
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= IDLE_LIMIT) begin
            $display("FAILURE");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // input driver
    always @(negedge aclk) begin
        xfer_t it;
        if (aresetn && !(s_tvalid && !taken)) begin
            if (send_gap > 0) begin
                send_gap--;
                s_tvalid <= 1'b0;
            end else if (pending.size() == 0) begin
                s_tvalid <= 1'b0;
            end else if (pending[0].sync) begin
                if (answers.size() == 0) pending[0].sync = 0;
                s_tvalid <= 1'b0;
            end else if (!calm && $urandom_range(0, 7) == 0) begin
                send_gap = $urandom_range(0, 3);
                s_tvalid <= 1'b0;
            end else begin
                it = pending.pop_front();
                if (it.hold) hold_req = 1;
                s_tuser <= it.mode;
                s_tdata <= {2'b00, it.py, it.px, it.ey, it.ex, it.sy, it.sx, it.owner};
                s_tvalid <= 1'b1;
            end
        end
    end

    // long receiver hold-off
    always @(negedge aclk) begin
        if (hold_req) begin
            hold_req = 0;
            hold_cnt = LONG_HOLD;
        end else if (hold_cnt > 0) begin
            hold_cnt--;
        end
    end

    // result receiver
    always @(negedge aclk) begin
        if (!aresetn || hold_cnt > 0) begin
            m_tready <= 1'b0;
        end else if (recv_gap > 0) begin
            recv_gap--;
            m_tready <= 1'b0;
        end else if (!calm && $urandom_range(0, 7) == 0) begin
            recv_gap = $urandom_range(0, 3);
            m_tready <= 1'b0;
        end else begin
            m_tready <= 1'b1;
        end
    end

    function automatic longint clampc(longint v);
        if (v > 8388607) return 8388607;
        if (v < -8388608) return -8388608;
        return v;
    endfunction

    function automatic longint pick(longint lo, longint hi);
        return lo + longint'($urandom_range(0, 32'(hi - lo)));
    endfunction

    function automatic logic [CW-1:0] rnd_coord();
        return CW'($urandom);
    endfunction

    task automatic put_edge(int own, longint sx, longint sy, longint ex, longint ey);
        xfer_t it;
        it = '{default: '0};
        it.mode = pio_pkg::MODE_APPEND;
        it.owner = OW'(own);
        it.sx = CW'(clampc(sx)); it.sy = CW'(clampc(sy));
        it.ex = CW'(clampc(ex)); it.ey = CW'(clampc(ey));
        it.px = rnd_coord(); it.py = rnd_coord();
        pending.push_back(it);
    endtask

    task automatic put_query(longint x, longint y, bit hold);
        xfer_t it;
        it = '{default: '0};
        it.mode = pio_pkg::MODE_QUERY;
        it.owner = OW'($urandom);
        it.sx = rnd_coord(); it.sy = rnd_coord(); it.ex = rnd_coord(); it.ey = rnd_coord();
        it.px = CW'(clampc(x)); it.py = CW'(clampc(y));
        it.hold = hold;
        pending.push_back(it);
    endtask

    task automatic put_plain(logic [pio_pkg::MODE_W-1:0] m, bit sync);
        xfer_t it;
        it = '{default: '0};
        it.mode = m;
        it.owner = OW'($urandom);
        it.sx = rnd_coord(); it.sy = rnd_coord(); it.ex = rnd_coord(); it.ey = rnd_coord();
        it.px = rnd_coord(); it.py = rnd_coord();
        it.sync = sync;
        pending.push_back(it);
    endtask

    // polygon with random vertices around a center; returns its first vertex
    task automatic put_polygon(int own, longint cx, longint cy, longint r,
                               output longint vx0, output longint vy0);
        longint vx[8], vy[8];
        int k;
        bit rev;
        k = $urandom_range(3, 6);
        rev = $urandom_range(0, 1);
        for (int i = 0; i < k; i++) begin
            if ($urandom_range(0, 3) == 0 && i > 0) begin
                vx[i] = vx[i - 1] + pick(-r, r);
                vy[i] = vy[i - 1];
            end else begin
                vx[i] = cx + pick(-r, r);
                vy[i] = cy + pick(-r, r);
            end
        end
        for (int i = 0; i < k; i++) begin
            if (rev) put_edge(own, vx[(i + 1) % k], vy[(i + 1) % k], vx[i], vy[i]);
            else     put_edge(own, vx[i], vy[i], vx[(i + 1) % k], vy[(i + 1) % k]);
        end
        vx0 = vx[0];
        vy0 = vy[0];
    endtask

    initial begin
        longint cx, cy, r, vx, vy, lastx, lasty;
        int npoly, nq, own;

        // directed part
        put_query(0, 0, 0);
        put_edge(63, -8388608, -8388608, 8388607, 8388607);
        put_edge(63, 8388607, 8388607, -8388608, 8388607);
        put_edge(63, -8388608, 8388607, -8388608, -8388608);
        put_query(100, 0, 0);
        put_query(0, 0, 0);
        put_query(-8388608, 0, 0);
        put_query(8388607, -8388608, 0);
        put_edge(0, 10, 5, 20, 5);
        put_query(0, 5, 0);
        put_plain(MODE_UNUSED, 0);
        put_plain(pio_pkg::MODE_CLEAR, 0);
        put_query(0, 0, 0);
        put_edge(5, 0, 0, 0, 10);
        put_edge(5, 0, 10, 10, 10);
        put_edge(5, 10, 10, 10, 0);
        put_edge(5, 10, 0, 0, 0);
        put_edge(6, 20, 0, 20, 10);
        put_edge(5, 30, 10, 30, 0);
        put_query(5, 5, 0);
        put_query(5, 10, 0);
        put_query(10, 5, 0);
        put_query(-5, 5, 0);
        put_query(25, 5, 0);
        put_plain(pio_pkg::MODE_CLEAR, 1);

        // random part: clear, a few polygons, queries mostly around them
        while (pending.size() < 480) begin
            put_plain(pio_pkg::MODE_CLEAR, 0);
            npoly = $urandom_range(1, 4);
            case ($urandom_range(0, 2))
                0: r = 8;
                1: r = 5000;
                default: r = 2097152;
            endcase
            for (int p = 0; p < npoly; p++) begin
                own = $urandom_range(0, 63);
                cx = pick(-8388608 + r, 8388607 - r);
                cy = pick(-8388608 + r, 8388607 - r);
                put_polygon(own, cx, cy, r, vx, vy);
                if ($urandom_range(0, 5) == 0)
                    put_edge(own, sext24(rnd_coord()), sext24(rnd_coord()),
                             sext24(rnd_coord()), sext24(rnd_coord()));
                if ($urandom_range(0, 9) == 0) put_plain(MODE_UNUSED, 0);
            end
            nq = $urandom_range(2, 5);
            for (int q = 0; q < nq; q++) begin
                case ($urandom_range(0, 5))
                    0: put_query(vx, vy, 0);
                    1: put_query(cx + pick(-r, r), vy, 0);
                    2: put_query(sext24(rnd_coord()), sext24(rnd_coord()), 0);
                    default: put_query(cx + pick(-2 * r, 2 * r), cy + pick(-2 * r, 2 * r), 0);
                endcase
            end
            if ($urandom_range(0, 15) == 0) put_plain(pio_pkg::MODE_CLEAR, 1);
        end
        put_plain(pio_pkg::MODE_CLEAR, 0);
        put_polygon(1, 0, 0, 50, lastx, lasty);
        put_query(0, 0, 1);
        for (int i = 0; i < 6; i++) begin
            put_edge(2, i, i, i + 1, -i);
            put_query(pick(-60, 60), pick(-60, 60), 0);
        end
        put_plain(pio_pkg::MODE_CLEAR, 1);
        for (int i = 0; i < 60; i++) put_query(pick(-60, 60), pick(-60, 60), 0);

        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        wait (pending.size() < 80);
        calm = 1;
        wait (pending.size() == 0 && !s_tvalid);
        wait (answers.size() == 0);
        repeat (200) @(posedge aclk);
        if (mismatches == 0 && answers.size() == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
